// ===== rtl/frame_cadence_servo_macros.svh =====
// ---------------------------------------------------------------------------
// frame_cadence_servo assertion macros
// Shared property shorthands for the cadence servo RTL.
// ---------------------------------------------------------------------------
`ifndef FRAME_CADENCE_SERVO_MACROS_SVH
`define FRAME_CADENCE_SERVO_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define FCS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define FCS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/fcs_pkg.sv =====
// ---------------------------------------------------------------------------
// fcs_pkg
// Widths, register codes, decision codes and controller/datapath bundles
// for the frame cadence servo.
// ---------------------------------------------------------------------------
package fcs_pkg;

	// Register file
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BASE_RATIO   = 3'd0,
		CFG_FRAME_PERIOD = 3'd1,
		CFG_SERVO_GAIN   = 3'd2,
		CFG_DEADBAND     = 3'd3,
		CFG_RESEEK_LIMIT = 3'd4,
		CFG_COOLDOWN     = 3'd5
	} cfg_idx_t;

	localparam logic [19:0] RST_BASE_RATIO   = 20'd163840;
	localparam logic [19:0] RST_FRAME_PERIOD = 20'd16667;
	localparam logic [15:0] RST_SERVO_GAIN   = 16'd1311;
	localparam logic [19:0] RST_DEADBAND     = 20'd65536;
	localparam logic [23:0] RST_RESEEK_LIMIT = 24'd500000;
	localparam logic [23:0] RST_COOLDOWN     = 24'd400000;

	// Result codes
	typedef enum logic [2:0] {
		DEC_SHOW   = 3'd0,
		DEC_DROP   = 3'd1,
		DEC_HOLD   = 3'd2,
		DEC_RESEEK = 3'd3,
		DEC_PAUSE  = 3'd4
	} dec_t;

	// Arithmetic constants
	localparam logic [15:0] SPEED_FLOOR = 16'd410;
	localparam logic [7:0]  HOLD_MAX    = 8'd255;
	localparam logic [16:0] Q_MAX       = 17'h10000;

	// Shared divider step counts (one quotient bit per cycle)
	localparam int          DIV_CNT_W        = 5;
	localparam logic [4:0]  DIV_RATIO_STEPS  = 5'd24;
	localparam logic [4:0]  DIV_TRIM_STEPS   = 5'd17;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic div_ratio;
		logic div_trim;
		logic save_ratio;
		logic save_q;
		logic sat_q;
		logic mul;
		logic commit;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic reseek;
		logic paused;
		logic div_busy;
		logic trim_need;
		logic trim_ovf;
	} status_t;

endpackage

// ===== rtl/fcs_datapath.sv =====
// ---------------------------------------------------------------------------
// fcs_datapath
// Register file, item registers, shared serial divider, trim multiplier,
// phase accumulator, reseek state and result registers.
// ---------------------------------------------------------------------------
module fcs_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [fcs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fcs_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic signed [24:0]             error_us,
	input  logic [15:0]                    speed,
	input  logic [31:0]                    now_us,
	input  logic                           paused,
	input  fcs_pkg::cmd_t                  cmd,
	output fcs_pkg::status_t               status,
	output logic [2:0]                     decision,
	output logic [7:0]                     hold_count
);

	// Configuration registers
	logic [19:0] base_q;
	logic [19:0] fp_q;
	logic [15:0] gain_q;
	logic [19:0] deadband_q;
	logic [23:0] limit_q;
	logic [23:0] cooldown_q;

	// Item registers
	logic [24:0] err_q;
	logic [15:0] speed_q;
	logic [31:0] now_q;
	logic        paused_q;

	// Persistent servo state
	logic [15:0] phase_q;
	logic [31:0] last_q;
	logic        seen_q;

	// Working registers
	logic [39:0] db_prod_q;
	logic [23:0] ratio_q;
	logic [16:0] q_q;
	logic [16:0] trim_mag_q;
	fcs_pkg::dec_t dec_q;
	logic [7:0]  hold_q;

	// Divider registers
	logic [19:0] div_rem_q;
	logic [23:0] div_num_q;
	logic [23:0] div_quo_q;
	logic [19:0] div_dvs_q;
	logic [fcs_pkg::DIV_CNT_W-1:0] div_cnt_q;
	logic        div_busy_q;

	// Combinational terms
	logic [24:0] emag;
	logic [19:0] fp_eff;
	logic [15:0] spd_eff;
	logic        reseek_hit;
	logic [31:0] since;
	logic        cool_hit;
	logic [20:0] div_shift;
	logic [21:0] div_trial;
	logic        div_neg;
	logic [32:0] trim_prod;
	logic [25:0] trim_s;
	logic [25:0] acc_next;
	logic [9:0]  acc_hold;
	logic        acc_drop;

	// Error magnitude and effective operands
	assign emag       = err_q[24] ? (~err_q + 25'd1) : err_q;
	assign fp_eff     = (fp_q == 20'd0) ? 20'd1 : fp_q;
	assign spd_eff    = (speed_q < fcs_pkg::SPEED_FLOOR) ? fcs_pkg::SPEED_FLOOR : speed_q;
	assign reseek_hit = emag > {1'b0, limit_q};
	assign since      = now_q - last_q;
	assign cool_hit   = seen_q && (since < {8'd0, cooldown_q});

	assign status.reseek    = reseek_hit;
	assign status.paused    = paused_q;
	assign status.div_busy  = div_busy_q;
	assign status.trim_need = {emag, 16'd0} > {1'b0, db_prod_q};
	assign status.trim_ovf  = emag >= {4'd0, fp_eff, 1'b0};

	// Divider step: one restoring subtract per cycle
	assign div_shift = {div_rem_q, div_num_q[23]};
	assign div_trial = {1'b0, div_shift} - {2'd0, div_dvs_q};
	assign div_neg   = div_trial[21];

	// Trim product and phase accumulator
	assign trim_prod = q_q * gain_q;
	assign trim_s    = err_q[24] ? (26'd0 - {9'd0, trim_mag_q}) : {9'd0, trim_mag_q};
	assign acc_next  = {10'd0, phase_q} + {2'd0, ratio_q} + trim_s;
	assign acc_hold  = acc_next[25:16];
	assign acc_drop  = acc_next[25] || (acc_hold == 10'd0);

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q     <= fcs_pkg::RST_BASE_RATIO;
			fp_q       <= fcs_pkg::RST_FRAME_PERIOD;
			gain_q     <= fcs_pkg::RST_SERVO_GAIN;
			deadband_q <= fcs_pkg::RST_DEADBAND;
			limit_q    <= fcs_pkg::RST_RESEEK_LIMIT;
			cooldown_q <= fcs_pkg::RST_COOLDOWN;
		end else if (cfg_we) begin
			case (fcs_pkg::cfg_idx_t'(cfg_index))
				fcs_pkg::CFG_BASE_RATIO:   base_q     <= cfg_data[19:0];
				fcs_pkg::CFG_FRAME_PERIOD: fp_q       <= cfg_data[19:0];
				fcs_pkg::CFG_SERVO_GAIN:   gain_q     <= cfg_data[15:0];
				fcs_pkg::CFG_DEADBAND:     deadband_q <= cfg_data[19:0];
				fcs_pkg::CFG_RESEEK_LIMIT: limit_q    <= cfg_data;
				fcs_pkg::CFG_COOLDOWN:     cooldown_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Capture the item and work values
	always_ff @(posedge clk) begin
		db_prod_q <= deadband_q * fp_eff;
		if (cmd.load) begin
			err_q      <= error_us;
			speed_q    <= speed;
			now_q      <= now_us;
			paused_q   <= paused;
			trim_mag_q <= 17'd0;
		end
		if (cmd.save_ratio)
			ratio_q <= div_quo_q;
		if (cmd.save_q)
			q_q <= (div_quo_q[16:0] > fcs_pkg::Q_MAX) ? fcs_pkg::Q_MAX : div_quo_q[16:0];
		else if (cmd.sat_q)
			q_q <= fcs_pkg::Q_MAX;
		if (cmd.mul)
			trim_mag_q <= trim_prod[32:16];
	end

	// Shared divider: load operands, then shift one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_cnt_q  <= '0;
		end else if (cmd.div_ratio || cmd.div_trim) begin
			div_busy_q <= 1'b1;
			div_cnt_q  <= cmd.div_ratio ? fcs_pkg::DIV_RATIO_STEPS : fcs_pkg::DIV_TRIM_STEPS;
		end else if (div_busy_q) begin
			div_cnt_q <= div_cnt_q - 1'b1;
			if (div_cnt_q == 5'd1)
				div_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_ratio) begin
			div_rem_q <= {8'd0, base_q[19:12]};
			div_num_q <= {base_q[11:0], 12'd0};
			div_dvs_q <= {4'd0, spd_eff};
			div_quo_q <= '0;
		end else if (cmd.div_trim) begin
			div_rem_q <= emag[20:1];
			div_num_q <= {emag[0], 23'd0};
			div_dvs_q <= fp_eff;
			div_quo_q <= '0;
		end else if (div_busy_q) begin
			div_rem_q <= div_neg ? div_shift[19:0] : div_trial[19:0];
			div_num_q <= {div_num_q[22:0], 1'b0};
			div_quo_q <= {div_quo_q[22:0], ~div_neg};
		end
	end

	// Update servo state at commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 16'd0;
			last_q  <= 32'd0;
			seen_q  <= 1'b0;
		end else if (cmd.commit) begin
			if (reseek_hit) begin
				if (!cool_hit) begin
					phase_q <= 16'd0;
					last_q  <= now_q;
					seen_q  <= 1'b1;
				end
			end else if (!paused_q) begin
				phase_q <= acc_next[15:0];
			end
		end
	end

	// Load the result word at commit
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (reseek_hit) begin
				dec_q  <= cool_hit ? fcs_pkg::DEC_HOLD : fcs_pkg::DEC_RESEEK;
				hold_q <= cool_hit ? 8'd1 : 8'd0;
			end else if (paused_q) begin
				dec_q  <= fcs_pkg::DEC_PAUSE;
				hold_q <= 8'd1;
			end else if (acc_drop) begin
				dec_q  <= fcs_pkg::DEC_DROP;
				hold_q <= 8'd0;
			end else begin
				dec_q  <= fcs_pkg::DEC_SHOW;
				hold_q <= (acc_hold[9:8] != 2'd0) ? fcs_pkg::HOLD_MAX : acc_hold[7:0];
			end
		end
	end

	assign decision   = dec_q;
	assign hold_count = hold_q;

endmodule

// ===== rtl/fcs_ctrl.sv =====
// ---------------------------------------------------------------------------
// fcs_ctrl
// Sequencer for one item: check; ratio division unless reseek or pause;
// optional trim division or saturation, multiply; commit to output register.
// ---------------------------------------------------------------------------
`include "frame_cadence_servo_macros.svh"

module fcs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	input  fcs_pkg::status_t status,
	output fcs_pkg::cmd_t    cmd
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_CHECK = 6'b000010,
		ST_RATIO = 6'b000100,
		ST_TRIM  = 6'b001000,
		ST_MUL   = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (status.reseek || status.paused) begin
					state_d = ST_DONE;
				end else begin
					cmd.div_ratio = 1'b1;
					state_d       = ST_RATIO;
				end
			end
			ST_RATIO: begin
				if (!status.div_busy) begin
					cmd.save_ratio = 1'b1;
					if (!status.trim_need) begin
						state_d = ST_DONE;
					end else if (status.trim_ovf) begin
						cmd.sat_q = 1'b1;
						state_d   = ST_MUL;
					end else begin
						cmd.div_trim = 1'b1;
						state_d      = ST_TRIM;
					end
				end
			end
			ST_TRIM: begin
				if (!status.div_busy) begin
					cmd.save_q = 1'b1;
					state_d    = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Advance state and track the output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	`FCS_ASSERT_IMPL(a_no_overwrite, out_valid && out_stall, !cmd.commit, "word overwritten")
	`FCS_ASSERT_NEXT(a_div_start, cmd.div_ratio || cmd.div_trim, status.div_busy, "divider idle")
	`FCS_ASSERT_NEXT(a_accept_check, in_valid && !in_stall, state_q == ST_CHECK, "check skipped")

endmodule

// ===== rtl/frame_cadence_servo.sv =====
// One source frame per input word; one decision word per input word. An
// item that ends in a reseek, a cooldown hold or a paused show goes straight
// from its check to commit; otherwise it runs the ratio division, then, when
// a trim applies, either saturates or runs a trim division, and multiplies.
// The block takes the next input word only once the current one commits.
// A single shared restoring divider produces one quotient bit per cycle:
// 24 bits for the speed-scaled ratio, 17 for the trim. A finished word waits
// in the output register while the next input word is taken. Configuration
// writes are always ready and must be issued only while no item is in flight.
// ---------------------------------------------------------------------------
// frame_cadence_servo
// Pulldown cadence phase accumulator with drift trim and rate-limited
// reseek requests.
// ---------------------------------------------------------------------------
module frame_cadence_servo (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [fcs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fcs_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [24:0]             error_us,
	input  logic [15:0]                    speed,
	input  logic [31:0]                    now_us,
	input  logic                           paused,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [2:0]                     decision,
	output logic [7:0]                     hold_count
);

	fcs_pkg::cmd_t    cmd;
	fcs_pkg::status_t status;
	logic             cfg_we;

	// Take register writes in any cycle
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	fcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	fcs_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.error_us   (error_us),
		.speed      (speed),
		.now_us     (now_us),
		.paused     (paused),
		.cmd        (cmd),
		.status     (status),
		.decision   (decision),
		.hold_count (hold_count)
	);

endmodule

// ===== test/frame_cadence_servo_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// frame_cadence_servo_tb
// Self-checking bench for the cadence servo. It drives source frames and
// register writes through the valid/stall and valid/ready channels, and
// predicts every decision word from its own copy of the phase, reseek and
// register state. Both sides idle at random, and one receiver hold-off backs
// the block up.
// ---------------------------------------------------------------------------

typedef struct {
	logic signed [24:0] error_us;
	logic [15:0]        speed;
	logic [31:0]        now_us;
	logic               paused;
} source_frame_t;

typedef struct {
	fcs_pkg::dec_t decision;
	logic [7:0]    hold;
} decision_word_t;

class cadence_scoreboard;
	bit [19:0] slot_ratio;
	bit [19:0] out_period;
	bit [15:0] trim_gain;
	bit [19:0] deadband;
	bit [23:0] reseek_limit;
	bit [23:0] cooldown;

	bit [15:0] phase_frac;
	bit [31:0] last_reseek_us;
	bit        reseek_armed;

	decision_word_t expected_words[$];
	int errors;
	int checked;
	int tally[8];

	function new();
		slot_ratio     = fcs_pkg::RST_BASE_RATIO;
		out_period     = fcs_pkg::RST_FRAME_PERIOD;
		trim_gain      = fcs_pkg::RST_SERVO_GAIN;
		deadband       = fcs_pkg::RST_DEADBAND;
		reseek_limit   = fcs_pkg::RST_RESEEK_LIMIT;
		cooldown       = fcs_pkg::RST_COOLDOWN;
		phase_frac     = '0;
		last_reseek_us = '0;
		reseek_armed   = 1'b0;
		errors         = 0;
		checked        = 0;
		foreach (tally[i])
			tally[i] = 0;
	endfunction

	function int pending();
		return expected_words.size();
	endfunction

	// Mirror a register write; unused indexes change nothing
	function void note_config(logic [fcs_pkg::CFG_IDX_W-1:0] idx,
			logic [fcs_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			fcs_pkg::CFG_BASE_RATIO:   slot_ratio   = data[19:0];
			fcs_pkg::CFG_FRAME_PERIOD: out_period   = data[19:0];
			fcs_pkg::CFG_SERVO_GAIN:   trim_gain    = data[15:0];
			fcs_pkg::CFG_DEADBAND:     deadband     = data[19:0];
			fcs_pkg::CFG_RESEEK_LIMIT: reseek_limit = data[23:0];
			fcs_pkg::CFG_COOLDOWN:     cooldown     = data[23:0];
			default: ;
		endcase
	endfunction

	// Advance the cadence state by one accepted frame and queue its decision
	function void note_frame(source_frame_t f);
		decision_word_t word;
		bit [24:0]      mag;
		bit [31:0]      since_reseek;
		bit [15:0]      spd;
		bit [63:0]      emag;
		bit [63:0]      period;
		bit [63:0]      scaled;
		bit [63:0]      band;
		bit [63:0]      wide_ratio;
		bit [63:0]      q;
		longint         ratio;
		longint         trim;
		longint         acc;
		longint         whole;

		mag = f.error_us;
		if (mag[24])
			mag = -mag;
		emag         = 64'(mag);
		period       = (out_period == 0) ? 64'd1 : 64'(out_period);
		since_reseek = f.now_us - last_reseek_us;

		if (emag > reseek_limit) begin
			// Large error: reseek unless the last one is too recent
			if (reseek_armed && since_reseek < cooldown) begin
				word = '{fcs_pkg::DEC_HOLD, 8'd1};
			end else begin
				word           = '{fcs_pkg::DEC_RESEEK, 8'd0};
				phase_frac     = '0;
				last_reseek_us = f.now_us;
				reseek_armed   = 1'b1;
			end
		end else if (f.paused) begin
			word = '{fcs_pkg::DEC_PAUSE, 8'd1};
		end else begin
			// Speed-scaled ratio with the speed floored at 0.1
			spd        = (f.speed < fcs_pkg::SPEED_FLOOR) ? fcs_pkg::SPEED_FLOOR : f.speed;
			wide_ratio = 64'(slot_ratio);
			wide_ratio = (wide_ratio << 12) / spd;
			ratio      = longint'(wide_ratio);

			// Proportional trim outside the deadband, error clamped to one frame
			trim   = 0;
			scaled = emag << 16;
			band   = 64'(deadband);
			band   = band * period;
			if (scaled > band) begin
				q = scaled / period;
				if (q > 64'd65536)
					q = 64'd65536;
				trim = longint'((q * 64'(trim_gain)) >> 16);
				if (f.error_us < 0)
					trim = -trim;
			end

			// Keep the fraction, the whole part is the slot count
			acc        = longint'(phase_frac) + ratio + trim;
			phase_frac = acc[15:0];
			whole      = acc >>> 16;
			if (whole <= 0)
				word = '{fcs_pkg::DEC_DROP, 8'd0};
			else if (whole > 255)
				word = '{fcs_pkg::DEC_SHOW, fcs_pkg::HOLD_MAX};
			else
				word = '{fcs_pkg::DEC_SHOW, 8'(whole)};
		end
		expected_words.insert(expected_words.size(), word);
	endfunction

	// Compare one accepted decision word with the oldest expectation
	function void check_decision(logic [2:0] decision, logic [7:0] hold);
		decision_word_t want;

		if (expected_words.size() == 0) begin
			errors++;
			$display("%0t: decision word with none expected: decision %0d hold_count %0d",
				$time, decision, hold);
			return;
		end
		want = expected_words[0];
		expected_words.delete(0);
		checked++;
		tally[want.decision]++;
		if (decision !== want.decision) begin
			errors++;
			$display("%0t: word %0d decision: expected %0d, actual %0d",
				$time, checked, want.decision, decision);
		end
		if (hold !== want.hold) begin
			errors++;
			$display("%0t: word %0d hold_count: expected %0d, actual %0d",
				$time, checked, want.hold, hold);
		end
	endfunction
endclass

module frame_cadence_servo_tb;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int SETTLE_CYCLES   = 60;
	localparam logic [fcs_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [fcs_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [fcs_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                           in_valid;
	logic                           in_stall;
	logic signed [24:0]             error_us;
	logic [15:0]                    speed;
	logic [31:0]                    now_us;
	logic                           paused;
	logic                           out_valid;
	logic                           out_stall;
	logic [2:0]                     decision;
	logic [7:0]                     hold_count;

	cadence_scoreboard board;
	bit [31:0]         wall_us;
	int                tx_gap_pct;
	int                rx_stall_pct;
	int                stall_left;
	int                quiet_cycles;
	int                frames_sent;
	int                settings_used;
	bit                hold_off_req;

	frame_cadence_servo uut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int pick_idle(int pct);
		if ($urandom_range(0, 99) >= pct)
			return 0;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(20, 80);
		return $urandom_range(1, 4);
	endfunction

	// Build a frame from a slowly advancing clock and the current settings
	function automatic source_frame_t next_random_frame();
		source_frame_t f;
		int unsigned   period;
		int unsigned   pick;
		longint        err;

		period = (board.out_period == 0) ? 1 : board.out_period;
		pick   = $urandom_range(0, 99);
		// Error: mostly near the deadband, some near or past the reseek limit
		if (pick < 55)
			err = longint'($urandom_range(0, 3 * period));
		else if (pick < 70)
			err = longint'(board.reseek_limit) + int'($urandom_range(0, 4)) - 2;
		else if (pick < 80)
			err = longint'(board.reseek_limit) + longint'($urandom_range(1, 2000000));
		else
			err = $signed(25'($urandom));
		if (pick < 80 && $urandom_range(0, 1) == 1)
			err = -err;
		if (err > 16777215)
			err = 16777215;
		if (err < -16777216)
			err = -16777216;
		f.error_us = err[24:0];

		pick = $urandom_range(0, 99);
		if (pick < 60)
			f.speed = 16'($urandom_range(2048, 12288));
		else if (pick < 75)
			f.speed = 16'($urandom_range(0, 410));
		else
			f.speed = 16'($urandom);

		if ($urandom_range(0, 19) == 0)
			wall_us = $urandom;
		else
			wall_us += $urandom_range(0, 2 * period);
		f.now_us = wall_us;
		f.paused = ($urandom_range(0, 9) == 0);
		return f;
	endfunction

	// Offer one frame after an optional gap; return at its acceptance
	task automatic send_frame(source_frame_t f, int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		error_us <= f.error_us;
		speed    <= f.speed;
		now_us   <= f.now_us;
		paused   <= f.paused;
		do @(posedge clk); while (in_stall);
		board.note_frame(f);
		frames_sent++;
	endtask

	task automatic offer_frame(int e, logic [15:0] s, logic [31:0] t, logic p);
		source_frame_t f;

		f = '{25'(e), s, t, p};
		send_frame(f, 0);
	endtask

	task automatic run_random(int count);
		repeat (count)
			send_frame(next_random_frame(), pick_idle(tx_gap_pct));
	endtask

	// Drop valid and let every decision word drain
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Hold valid across back-to-back writes; the caller lowers it
	task automatic write_reg(logic [fcs_pkg::CFG_IDX_W-1:0] idx,
			logic [fcs_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		board.note_config(idx, data);
	endtask

	task automatic apply_settings(bit [19:0] ratio, bit [19:0] period, bit [15:0] gain,
			bit [19:0] band, bit [23:0] limit, bit [23:0] cool);
		write_reg(fcs_pkg::CFG_BASE_RATIO, 24'(ratio));
		write_reg(fcs_pkg::CFG_FRAME_PERIOD, 24'(period));
		write_reg(fcs_pkg::CFG_SERVO_GAIN, 24'(gain));
		write_reg(fcs_pkg::CFG_DEADBAND, 24'(band));
		write_reg(fcs_pkg::CFG_RESEEK_LIMIT, limit);
		write_reg(fcs_pkg::CFG_COOLDOWN, cool);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// Check accepted words, then pick the stall for the next cycle
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_decision(decision, hold_count);
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (hold_off_req) begin
			hold_off_req = 1'b0;
			out_stall    <= 1'b1;
			stall_left   = HOLD_OFF_CYCLES - 1;
		end else begin
			stall_left = pick_idle(rx_stall_pct);
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Stop a run that no longer moves any word
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		board         = new();
		frames_sent   = 0;
		settings_used = 1;
		tx_gap_pct    = 0;
		rx_stall_pct  = 0;
		stall_left    = 0;
		quiet_cycles  = 0;
		hold_off_req  = 1'b0;
		wall_us       = '0;
		arst_n    <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		error_us  <= '0;
		speed     <= '0;
		now_us    <= '0;
		paused    <= 1'b0;
		out_stall <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames under reset settings
		offer_frame(0, 16'd4096, 32'd0, 1'b0);           // steady 2.5 slot cadence
		offer_frame(0, 16'd4096, 32'd16667, 1'b0);
		offer_frame(0, 16'd4096, 32'd33333, 1'b1);       // paused show
		offer_frame(20000, 16'd4096, 32'd50000, 1'b0);   // trim by division
		offer_frame(-20000, 16'd4096, 32'd66667, 1'b0);
		offer_frame(16667, 16'd4096, 32'd83333, 1'b0);   // on the deadband edge
		offer_frame(16668, 16'd4096, 32'd100000, 1'b0);  // just outside it
		offer_frame(100000, 16'd4096, 32'd116667, 1'b0); // trim saturates
		offer_frame(-100000, 16'd4096, 32'd133333, 1'b0);
		offer_frame(0, 16'd0, 32'd150000, 1'b0);         // speed below floor
		offer_frame(0, 16'd409, 32'd166667, 1'b0);
		offer_frame(0, 16'd410, 32'd183333, 1'b0);
		offer_frame(0, 16'hFFFF, 32'd200000, 1'b0);      // fast play drops
		offer_frame(-400000, 16'hFFFF, 32'd216667, 1'b0);
		offer_frame(500000, 16'd4096, 32'd233333, 1'b0); // at the limit, no reseek
		offer_frame(16777215, 16'd4096, 32'd300000, 1'b0);
		offer_frame(-16777216, 16'd4096, 32'd310000, 1'b0); // held in cooldown
		offer_frame(500001, 16'd4096, 32'd320000, 1'b1);    // reseek test beats pause
		offer_frame(-500001, 16'd4096, 32'd700000, 1'b0);   // cooldown just over
		offer_frame(600000, 16'd4096, 32'hFFFF_FF00, 1'b0);
		offer_frame(600000, 16'd4096, 32'h0000_0100, 1'b0); // held across the wrap
		offer_frame(0, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
		offer_frame(0, 16'd4096, 32'h0000_0200, 1'b0);
		offer_frame(16777215, 16'hFFFF, 32'h8000_0000, 1'b1);

		wall_us      = 32'd2000000;
		tx_gap_pct   = 30;
		rx_stall_pct = 30;
		run_random(250);

		// Every register at its floor, zero frame period among them
		wait_idle();
		apply_settings(20'd0, 20'd0, 16'd0, 20'd0, 24'd0, 24'd0);
		run_random(120);

		// Registers at or near their ceilings; cross the time wrap without idling
		wait_idle();
		apply_settings(20'hFFFFF, 20'd1000000, 16'hFFFF, 20'd524288, 24'hFFFFFF, 24'hFFFFFF);
		wall_us      = 32'hFFF0_0000;
		tx_gap_pct   = 0;
		rx_stall_pct = 0;
		run_random(200);

		// Mixed extremes, with a write to an unused index first
		wait_idle();
		write_reg(CFG_UNUSED, 24'($urandom));
		apply_settings(20'hFFFFF, 20'd1, 16'hFFFF, 20'd0, 24'd300000, 24'd0);
		tx_gap_pct   = 50;
		rx_stall_pct = 50;
		run_random(150);

		// Random settings; one phase backs the block up behind a long hold-off
		for (int p = 0; p < 4; p++) begin
			wait_idle();
			apply_settings(
				($urandom_range(0, 3) == 0) ? 20'($urandom_range(0, 20'hFFFFF))
					: 20'($urandom_range(40000, 330000)),
				20'($urandom_range(1000, 50000)),
				16'($urandom_range(0, 16'hFFFF)),
				20'($urandom_range(0, 262144)),
				24'($urandom_range(10000, 2000000)),
				24'($urandom_range(0, 1000000)));
			tx_gap_pct   = (p == 1) ? 0 : int'($urandom_range(0, 60));
			rx_stall_pct = int'($urandom_range(0, 60));
			if (p == 1)
				hold_off_req = 1'b1;
			run_random(160);
		end

		wait_idle();
		$display("Sent %0d source frames under %0d register settings; checked %0d words.",
			frames_sent, settings_used, board.checked);
		$display("Decisions seen: show %0d, drop %0d, cooldown hold %0d, reseek %0d, paused %0d",
			board.tally[fcs_pkg::DEC_SHOW], board.tally[fcs_pkg::DEC_DROP],
			board.tally[fcs_pkg::DEC_HOLD], board.tally[fcs_pkg::DEC_RESEEK],
			board.tally[fcs_pkg::DEC_PAUSE]);
		if (board.errors == 0 && board.pending() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
